[sv/swpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_pkg
// Shared constants, types and the CRC-16 byte step for the servo write
// packet framer.
// ----------------------------------------------------------------------------
package swpf_pkg;

	localparam int MAX_DATA_BYTES = 4;
	localparam int CNT_W          = $clog2(MAX_DATA_BYTES + 1);
	localparam int DATA_W         = 32;
	localparam int IDX_W          = $clog2(MAX_DATA_BYTES + 12);

	localparam int HDR_LEN_V1 = 6;
	localparam int HDR_LEN_V2 = 10;

	localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
	localparam logic [7:0]  HDR3_BYTE   = 8'hFD;
	localparam logic [7:0]  ZERO_BYTE   = 8'h00;
	localparam logic [7:0]  WRITE_INSTR = 8'h03;
	localparam logic [15:0] CRC_POLY    = 16'h8005;

	localparam logic [1:0] CFG_IDX_SERVO_ID = 2'd0;
	localparam logic [1:0] CFG_IDX_FRAMING  = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// Control from the sequencer to the check unit.
	typedef struct packed {
		logic       clear;
		logic       update;
		logic       crc_mode;
		logic [7:0] data;
	} chk_ctrl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[sv/swpf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf interfaces
// Command, byte stream and configuration write channels.
// ----------------------------------------------------------------------------
interface swpf_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [7:0]                   reg_address;
	logic [2:0]                   data_count;
	logic [swpf_pkg::DATA_W-1:0]  data_value;

	modport source (output valid, reg_address, data_count, data_value, input ready);
	modport sink   (input valid, reg_address, data_count, data_value, output ready);
endinterface

interface swpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, tx_byte, last_byte, input ready);
	modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

interface swpf_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] reg_index;
	logic [7:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[sv/swpf_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_chk
// Shared check unit: folds one packet byte per cycle while update is set
// into either the CRC-16 or the 8-bit running sum.
// ----------------------------------------------------------------------------
module swpf_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  swpf_pkg::chk_ctrl_t ctrl,
	output logic [15:0]         chk
);

	logic [15:0] chk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 16'h0000;
		end else if (ctrl.clear) begin
			chk_q <= 16'h0000;
		end else if (ctrl.update) begin
			if (ctrl.crc_mode) begin
				chk_q <= swpf_pkg::crc_byte(chk_q, ctrl.data);
			end else begin
				chk_q <= {8'h00, chk_q[7:0] + ctrl.data};
			end
		end
	end

	assign chk = chk_q;

endmodule

[sv/swpf_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_seq
// Packet sequencer: latches a command, steps a byte index through the
// packet and drives the registered byte output.
// ----------------------------------------------------------------------------
module swpf_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	swpf_cmd_if.sink                 cmd,
	swpf_byte_if.source              pkt,
	input  logic [7:0]               servo_id,
	input  logic                     framing_version,
	input  logic [15:0]              chk,
	output swpf_pkg::chk_ctrl_t      chk_ctrl
);

	localparam int IDX_W = swpf_pkg::IDX_W;
	localparam int CNT_W = swpf_pkg::CNT_W;

	swpf_pkg::state_t                state_q;
	logic [IDX_W-1:0]                idx_q;
	logic [IDX_W-1:0]                end_idx_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            ver_q;
	logic [7:0]                      id_q;
	logic [7:0]                      addr_q;
	logic [swpf_pkg::DATA_W-1:0]     data_q;
	logic                            out_valid_q;
	logic [7:0]                      byte_q;
	logic                            last_q;

	logic                            accept;
	logic                            load;
	logic [CNT_W:0]                  cnt_in;
	logic [CNT_W-1:0]                cnt_clamp;
	logic [IDX_W-1:0]                hdr_len;
	logic [IDX_W-1:0]                data_end;
	logic                            is_hdr;
	logic                            is_data;
	logic                            is_chk_lo;
	logic                            is_last;
	logic [15:0]                     len16;
	logic [7:0]                      hdr_byte;
	logic [7:0]                      cur_byte;

	assign cmd.ready = (state_q == swpf_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign load      = (state_q == swpf_pkg::ST_RUN) && (!out_valid_q || pkt.ready);

	// Clamp the count to 1..MAX_DATA_BYTES.
	always_comb begin
		cnt_in = (CNT_W + 1)'(cmd.data_count);
		if (cnt_in == '0) begin
			cnt_clamp = CNT_W'(1);
		end else if (cnt_in > (CNT_W + 1)'(swpf_pkg::MAX_DATA_BYTES)) begin
			cnt_clamp = CNT_W'(swpf_pkg::MAX_DATA_BYTES);
		end else begin
			cnt_clamp = cnt_in[CNT_W-1:0];
		end
	end

	assign hdr_len   = ver_q ? IDX_W'(swpf_pkg::HDR_LEN_V2) : IDX_W'(swpf_pkg::HDR_LEN_V1);
	assign data_end  = hdr_len + IDX_W'(cnt_q);
	assign is_hdr    = idx_q < hdr_len;
	assign is_data   = !is_hdr && (idx_q < data_end);
	assign is_chk_lo = idx_q == data_end;
	assign is_last   = idx_q == end_idx_q;
	assign len16     = 16'(cnt_q) + (ver_q ? 16'd5 : 16'd3);

	always_comb begin
		hdr_byte = swpf_pkg::ZERO_BYTE;
		if (ver_q) begin
			case (idx_q)
				IDX_W'(0): hdr_byte = swpf_pkg::SYNC_BYTE;
				IDX_W'(1): hdr_byte = swpf_pkg::SYNC_BYTE;
				IDX_W'(2): hdr_byte = swpf_pkg::HDR3_BYTE;
				IDX_W'(3): hdr_byte = swpf_pkg::ZERO_BYTE;
				IDX_W'(4): hdr_byte = id_q;
				IDX_W'(5): hdr_byte = len16[7:0];
				IDX_W'(6): hdr_byte = len16[15:8];
				IDX_W'(7): hdr_byte = swpf_pkg::WRITE_INSTR;
				IDX_W'(8): hdr_byte = addr_q;
				default:   hdr_byte = swpf_pkg::ZERO_BYTE;
			endcase
		end else begin
			case (idx_q)
				IDX_W'(0): hdr_byte = swpf_pkg::SYNC_BYTE;
				IDX_W'(1): hdr_byte = swpf_pkg::SYNC_BYTE;
				IDX_W'(2): hdr_byte = id_q;
				IDX_W'(3): hdr_byte = len16[7:0];
				IDX_W'(4): hdr_byte = swpf_pkg::WRITE_INSTR;
				IDX_W'(5): hdr_byte = addr_q;
				default:   hdr_byte = swpf_pkg::ZERO_BYTE;
			endcase
		end
	end

	always_comb begin
		if (is_hdr) begin
			cur_byte = hdr_byte;
		end else if (is_data) begin
			cur_byte = data_q[7:0];
		end else if (is_chk_lo) begin
			cur_byte = ver_q ? chk[7:0] : ~chk[7:0];
		end else begin
			cur_byte = chk[15:8];
		end
	end

	// The older sum starts at the id byte.
	always_comb begin
		chk_ctrl.clear    = accept;
		chk_ctrl.update   = load && (is_hdr || is_data) && (ver_q || idx_q >= IDX_W'(2));
		chk_ctrl.crc_mode = ver_q;
		chk_ctrl.data     = cur_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swpf_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				swpf_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= swpf_pkg::ST_RUN;
						idx_q   <= '0;
					end
				end
				swpf_pkg::ST_RUN: begin
					if (load) begin
						if (is_last) begin
							state_q <= swpf_pkg::ST_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= swpf_pkg::ST_IDLE;
					idx_q   <= '0;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pkt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q     <= cnt_clamp;
			ver_q     <= framing_version;
			id_q      <= servo_id;
			addr_q    <= cmd.reg_address;
			data_q    <= cmd.data_value;
			// index of the final check byte
			end_idx_q <= IDX_W'(cnt_clamp) + (framing_version ? IDX_W'(11) : IDX_W'(6));
		end else if (load && is_data) begin
			// advance to the next data byte, zero fill from the top
			data_q <= {8'h00, data_q[swpf_pkg::DATA_W-1:8]};
		end
		if (load) begin
			byte_q <= cur_byte;
			last_q <= is_last;
		end
	end

	assign pkt.valid     = out_valid_q;
	assign pkt.tx_byte   = byte_q;
	assign pkt.last_byte = last_q;

`ifndef SYNTHESIS
	a_idle_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swpf_pkg::ST_IDLE |-> idx_q == '0)
		else $error("byte index not cleared while idle");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == swpf_pkg::ST_RUN)
		else $error("command accepted but sequencer not running");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && is_last |=> state_q == swpf_pkg::ST_IDLE && out_valid_q && last_q)
		else $error("final word did not end the packet");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swpf_pkg::ST_RUN |-> idx_q <= end_idx_q)
		else $error("byte index ran past packet length");
`endif

endmodule

[sv/servo_write_packet_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_write_packet_framer_unit
// Frames a register-write command into a serial servo bus packet, one byte
// per output word, with the last check byte marked.
// ----------------------------------------------------------------------------
// Channels: cmd takes one command word (address, data count, data value);
// pkt delivers the packet one byte per word, last_byte set on the final
// check byte; cfg writes servo_id (index 0) and framing_version (index 1),
// always ready, other indexes ignored.
// A command is accepted only while the sequencer is idle. The packet then
// leaves at one byte per cycle while the receiver is ready, from a single
// output register: the first byte is loaded once the sequencer is running,
// and a packet is count + 12 bytes in the newer framing, count + 7 in the
// older one. The check unit folds one byte per cycle (CRC-16 or running sum)
// as header and data bytes are loaded, so the sequencer's byte counter sets
// the rate; the next command is taken the cycle after the last byte is
// loaded into the output register.
// Reset clears the sequencer and output valid and restores servo_id = 1 and
// the newer framing. When the receiver stalls, the output word holds and the
// sequencer waits; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module servo_write_packet_framer_unit (
	input  logic         clk,
	input  logic         arst_n,
	swpf_cmd_if.sink     cmd,
	swpf_byte_if.source  pkt,
	swpf_cfg_if.sink     cfg
);

	logic [7:0]          servo_id_q;
	logic                framing_version_q;
	logic [15:0]         chk;
	swpf_pkg::chk_ctrl_t chk_ctrl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_id_q        <= 8'd1;
			framing_version_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				swpf_pkg::CFG_IDX_SERVO_ID: servo_id_q        <= cfg.wr_data;
				swpf_pkg::CFG_IDX_FRAMING:  framing_version_q <= cfg.wr_data[0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	swpf_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.pkt             (pkt),
		.servo_id        (servo_id_q),
		.framing_version (framing_version_q),
		.chk             (chk),
		.chk_ctrl        (chk_ctrl)
	);

	swpf_chk u_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (chk_ctrl),
		.chk    (chk)
	);

endmodule
